FILE: hdl/lpc_pkg.sv
// Shared types and codes for the LRU page cache with write-back.
package lpc_pkg;

   localparam int PAGE_W   = 16;
   localparam int HANDLE_W = 8;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_MARK   = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISS    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_FLUSHED = 2'd3
   } status_type;

   // One tag store word: page tag and buffer handle
   typedef struct packed {
      logic [PAGE_W-1:0]   page;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_EVICT,
      S_FLUSH_SEL,
      S_FLUSH_EMIT
   } state_type;

endpackage

FILE: hdl/lru_page_cache_writeback_top.sv
// Top level: LRU page cache sequencer, dirty marks and response register.
//
//   channel  ports                                   dir   word
//   req      req_valid/req_stall, req_operation,     in    one cache command
//            req_page_number, req_page_handle
//   rsp      rsp_valid/rsp_stall, rsp_status, ...,   out   one result, rsp_last
//            rsp_last                                      ends a command
//
// Lookup, insert and mark dirty scan the filled slots through one tag store
// read port and one tag comparator, one slot per cycle; a full cache insert
// then reads and evicts the least recent slot. Flush walks recency ranks one
// per cycle, pausing at each dirty slot to read it and send its word.
// Reset is synchronous; it empties the cache and clears all dirty marks.
// A stalled response holds the sequencer at its next result; a new command
// is taken while the last result of the previous one waits.
module lru_page_cache_writeback_top
   import lpc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic [HANDLE_W-1:0] req_page_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [HANDLE_W-1:0] rsp_found_handle,
   output logic                rsp_victim_valid,
   output logic [PAGE_W-1:0]   rsp_victim_page,
   output logic [HANDLE_W-1:0] rsp_victim_handle,
   output logic                rsp_write_back,
   output logic                rsp_last
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_RANK = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] FULL     = CW'(ENTRIES);

   // Control state
   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Command and working payload
   op_type              op_ff, op_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   logic                hit_ff, hit_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic [HANDLE_W-1:0] found_ff, found_in;
   logic [IW-1:0]       pos_ff, pos_in;

   // Response payload
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_found_ff, rsp_found_in;
   logic                rsp_vv_ff, rsp_vv_in;
   logic [PAGE_W-1:0]   rsp_vpage_ff, rsp_vpage_in;
   logic [HANDLE_W-1:0] rsp_vhandle_ff, rsp_vhandle_in;
   logic                rsp_wb_ff, rsp_wb_in;
   logic                rsp_last_ff, rsp_last_in;

   // Tag store and recency hookup
   logic                rd_en, wr_en;
   logic [IW-1:0]       rd_addr;
   entry_type           rd_data, wr_data;
   logic                prom_en;
   logic [IW-1:0]       find_rank, find_slot;

   logic                out_free;
   logic                hit_now;
   logic [ENTRIES-1:0]  slot_mask;

   lpc_tag_ram #(.ENTRIES(ENTRIES), .IW(IW)) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lpc_recency #(.ENTRIES(ENTRIES), .IW(IW)) u_recency (
      .clock     (clock),
      .reset     (reset),
      .prom_en   (prom_en),
      .prom_slot (slot_ff),
      .find_rank (find_rank),
      .find_slot (find_slot)
   );

   assign wr_data   = '{page: page_ff, handle: handle_ff};
   assign find_rank = (state_ff == S_FLUSH_SEL) ? pos_ff : LAST_RANK;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit_now   = pend_ff && (rd_data.page == page_ff);
   assign slot_mask = {{(ENTRIES-1){1'b0}}, 1'b1} << slot_ff;
   assign req_stall = (state_ff != S_IDLE);

   // Sequencer: next state, store control and response words
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      scan_in   = scan_ff;
      pend_in   = 1'b0;
      dirty_in  = dirty_ff;
      op_in     = op_ff;
      page_in   = page_ff;
      handle_in = handle_ff;
      pidx_in   = pidx_ff;
      hit_in    = hit_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      prom_en   = 1'b0;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_vv_in      = rsp_vv_ff;
      rsp_vpage_in   = rsp_vpage_ff;
      rsp_vhandle_in = rsp_vhandle_ff;
      rsp_wb_in      = rsp_wb_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               page_in   = req_page_number;
               handle_in = req_page_handle;
               scan_in   = '0;
               pos_in    = '0;
               hit_in    = 1'b0;
               if (op_type'(req_operation) == OP_FLUSH) begin
                  state_in = (dirty_ff == '0) ? S_FINISH : S_FLUSH_SEL;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         // one tag read issued and one compared per cycle
         S_SCAN: begin
            if (hit_now) begin
               hit_in   = 1'b1;
               slot_in  = pidx_ff;
               found_in = rd_data.handle;
               state_in = S_FINISH;
            end else if (scan_ff != fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff[IW-1:0];
               pend_in = 1'b1;
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               hit_in = 1'b0;
               if (op_ff == OP_INSERT && fill_ff == FULL) begin
                  // least recent slot is the victim
                  slot_in  = find_slot;
                  rd_en    = 1'b1;
                  rd_addr  = find_slot;
                  state_in = S_EVICT;
               end else begin
                  slot_in  = fill_ff[IW-1:0];
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_DONE;
               rsp_found_in   = '0;
               rsp_vv_in      = 1'b0;
               rsp_vpage_in   = '0;
               rsp_vhandle_in = '0;
               rsp_wb_in      = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
               case (op_ff)
                  OP_LOOKUP: begin
                     if (hit_ff) begin
                        prom_en      = 1'b1;
                        rsp_found_in = found_ff;
                     end else begin
                        rsp_status_in = ST_MISS;
                     end
                  end
                  OP_MARK: begin
                     if (hit_ff) begin
                        dirty_in     = dirty_ff | slot_mask;
                        rsp_found_in = found_ff;
                     end else begin
                        rsp_status_in = ST_MISS;
                     end
                  end
                  OP_INSERT: begin
                     prom_en = 1'b1;
                     if (hit_ff) begin
                        rsp_status_in = ST_PRESENT;
                        rsp_found_in  = found_ff;
                     end else begin
                        // fill the next free slot, new entry is clean
                        wr_en    = 1'b1;
                        dirty_in = dirty_ff & ~slot_mask;
                        fill_in  = fill_ff + 1'b1;
                     end
                  end
                  default: begin
                     // flush with nothing dirty: a single done word
                     rsp_status_in = ST_DONE;
                  end
               endcase
            end
         end

         // victim word comes from the read issued at scan end
         S_EVICT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_DONE;
               rsp_found_in   = '0;
               rsp_vv_in      = 1'b1;
               rsp_vpage_in   = rd_data.page;
               rsp_vhandle_in = rd_data.handle;
               rsp_wb_in      = dirty_ff[slot_ff];
               rsp_last_in    = 1'b1;
               wr_en          = 1'b1;
               prom_en        = 1'b1;
               dirty_in       = dirty_ff & ~slot_mask;
               state_in       = S_IDLE;
            end
         end

         // walk ranks from most recent, stop on a dirty slot
         S_FLUSH_SEL: begin
            if (dirty_ff[find_slot]) begin
               rd_en    = 1'b1;
               rd_addr  = find_slot;
               slot_in  = find_slot;
               state_in = S_FLUSH_EMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         S_FLUSH_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_FLUSHED;
               rsp_found_in   = '0;
               rsp_vv_in      = 1'b1;
               rsp_vpage_in   = rd_data.page;
               rsp_vhandle_in = rd_data.handle;
               rsp_wb_in      = 1'b1;
               rsp_last_in    = ((dirty_ff & ~slot_mask) == '0);
               dirty_in       = dirty_ff & ~slot_mask;
               if ((dirty_ff & ~slot_mask) == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_FLUSH_SEL;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      page_ff        <= page_in;
      handle_ff      <= handle_in;
      pidx_ff        <= pidx_in;
      hit_ff         <= hit_in;
      slot_ff        <= slot_in;
      found_ff       <= found_in;
      pos_ff         <= pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_vv_ff      <= rsp_vv_in;
      rsp_vpage_ff   <= rsp_vpage_in;
      rsp_vhandle_ff <= rsp_vhandle_in;
      rsp_wb_ff      <= rsp_wb_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_handle  = rsp_found_ff;
   assign rsp_victim_valid  = rsp_vv_ff;
   assign rsp_victim_page   = rsp_vpage_ff;
   assign rsp_victim_handle = rsp_vhandle_ff;
   assign rsp_write_back    = rsp_wb_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: hdl/lpc_tag_ram.sv
// Tag store: one write port, one read port with registered read data.
module lpc_tag_ram
   import lpc_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [ENTRIES];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lpc_recency.sv
// Recency ranks per slot: move-to-front update and rank-to-slot search.
module lpc_recency #(
   parameter int ENTRIES = 16,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          prom_en,
   input  logic [IW-1:0] prom_slot,
   input  logic [IW-1:0] find_rank,
   output logic [IW-1:0] find_slot
);

   // rank 0 is most recent; filled slots hold a permutation of 0..fill-1,
   // unfilled slot j keeps rank j
   logic [IW-1:0] rank_ff [ENTRIES];
   logic [IW-1:0] rank_in [ENTRIES];
   logic [IW-1:0] thr;

   // Rank of the promoted slot
   always_comb begin
      thr = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (IW'(i) == prom_slot) begin
            thr = thr | rank_ff[i];
         end
      end
   end

   // Promote: slot goes to rank 0, everything more recent ages by one
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (prom_en) begin
            if (IW'(i) == prom_slot) begin
               rank_in[i] = '0;
            end else if (rank_ff[i] < thr) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= IW'(i);
         end
      end else begin
         rank_ff <= rank_in;
      end
   end

   // Slot holding the requested rank (exactly one matches)
   always_comb begin
      find_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (rank_ff[i] == find_rank) begin
            find_slot = find_slot | IW'(i);
         end
      end
   end

endmodule
